// File: rtl/rle8_pkg.sv
// Shared types and constants for the BMP RLE8 run encoder.
package rle8_pkg;

    // Field widths.
    localparam int PIXEL_W  = 8;
    localparam int COUNT_W  = 8;

    // Longest run that one pair can carry.
    localparam logic [COUNT_W-1:0] RUN_MAX = 8'd255;

    // Escape codes carried in the value byte of a zero-count pair.
    localparam logic [PIXEL_W-1:0] ESC_EOL = 8'd0;
    localparam logic [PIXEL_W-1:0] ESC_EOF = 8'd1;

    // Most result pairs that one pixel can cause.
    localparam int MAX_RES  = 4;
    localparam int SLOT_W   = $clog2(MAX_RES);
    localparam int NUM_W    = $clog2(MAX_RES + 1);

    // One encoded pair plus its end-of-image mark.
    typedef struct packed {
        logic [COUNT_W-1:0] run_count;
        logic [PIXEL_W-1:0] run_value;
        logic               last;
    } res_t;

endpackage

// File: rtl/bmp_rle8_run_encoder_top.sv
// Top level of the BMP RLE8 run encoder.
//
// Input channel (s_*): one pixel per item. s_tdata carries the pixel,
// s_tlast marks the last pixel of a row and s_tuser the last pixel of the
// image (which also closes the row).
// Output channel (m_*): one (count, value) pair per item. A count of zero
// marks an escape pair: value 0 ends a line, value 1 ends the file. m_tlast
// is set on the end-of-file pair only.
// Latency: the first pair caused by a pixel appears the cycle after the
// pixel is accepted.
// Throughput: a pixel causes 0 to 4 pairs, which are held in a four-slot
// result register and sent one per cycle. A new pixel is taken in the same
// cycle that the last waiting pair leaves, so the pairs of one pixel all
// leave before the next pixel's pairs, and pixels that cause at most one pair
// flow at one per clock. The output port, one pair per cycle, sets the rate.
// When the receiver stalls, the waiting pairs hold and s_tready stays low.
// Reset clears the open run and drops any waiting pairs.
module bmp_rle8_run_encoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic        s_tlast,   // row_end
    input  logic        s_tuser,   // image_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] run_count, [15:8] run_value
    output logic        m_tlast    // last
);

    // Run state.
    logic [rle8_pkg::PIXEL_W-1:0] held_value_reg, held_value_next;
    logic [rle8_pkg::COUNT_W-1:0] held_count_reg, held_count_next;
    logic                         run_open_reg, run_open_next;

    // Result slots, slot 0 is presented on the output.
    rle8_pkg::res_t               slot_reg [rle8_pkg::MAX_RES];
    rle8_pkg::res_t               slot_next [rle8_pkg::MAX_RES];
    logic [rle8_pkg::NUM_W-1:0]   num_reg, num_next;

    logic                         accept;
    logic                         pop;
    logic                         eol;
    logic                         extend;
    logic [rle8_pkg::PIXEL_W-1:0] run_val;
    logic [rle8_pkg::COUNT_W-1:0] run_cnt;
    rle8_pkg::res_t               lst [rle8_pkg::MAX_RES];
    logic [rle8_pkg::NUM_W-1:0]   lst_num;

    // Handshakes: a pixel enters when no pair will be left waiting.
    assign m_tvalid = (num_reg != '0);
    assign pop      = m_tvalid & m_tready;
    assign s_tready = (num_reg == '0) ||
                      ((num_reg == rle8_pkg::NUM_W'(1)) && m_tready);
    assign accept   = s_tvalid & s_tready;

    assign m_tdata  = {slot_reg[0].run_value, slot_reg[0].run_count};
    assign m_tlast  = slot_reg[0].last;

    // Run update for the incoming pixel.
    assign eol    = s_tlast | s_tuser;
    assign extend = run_open_reg && (s_tdata == held_value_reg) &&
                    (held_count_reg < rle8_pkg::RUN_MAX);
    assign run_val = extend ? held_value_reg : s_tdata;
    assign run_cnt = extend ? (held_count_reg + rle8_pkg::COUNT_W'(1))
                            : rle8_pkg::COUNT_W'(1);

    // Build the ordered list of pairs this pixel causes.
    always_comb
    begin
        for (int i = 0; i < rle8_pkg::MAX_RES; i++)
        begin
            lst[i] = '0;
        end
        lst_num = '0;
        if (run_open_reg && !extend)
        begin
            lst[lst_num[rle8_pkg::SLOT_W-1:0]] = '{held_count_reg, held_value_reg, 1'b0};
            lst_num = lst_num + rle8_pkg::NUM_W'(1);
        end
        if (eol)
        begin
            lst[lst_num[rle8_pkg::SLOT_W-1:0]] = '{run_cnt, run_val, 1'b0};
            lst_num = lst_num + rle8_pkg::NUM_W'(1);
            lst[lst_num[rle8_pkg::SLOT_W-1:0]] = '{'0, rle8_pkg::ESC_EOL, 1'b0};
            lst_num = lst_num + rle8_pkg::NUM_W'(1);
        end
        if (s_tuser)
        begin
            lst[lst_num[rle8_pkg::SLOT_W-1:0]] = '{'0, rle8_pkg::ESC_EOF, 1'b1};
            lst_num = lst_num + rle8_pkg::NUM_W'(1);
        end
    end

    // Next run state: a row end closes everything.
    always_comb
    begin
        held_value_next = held_value_reg;
        held_count_next = held_count_reg;
        run_open_next   = run_open_reg;
        if (accept)
        begin
            if (eol)
            begin
                held_value_next = '0;
                held_count_next = '0;
                run_open_next   = 1'b0;
            end
            else
            begin
                held_value_next = run_val;
                held_count_next = run_cnt;
                run_open_next   = 1'b1;
            end
        end
    end

    // Result slots: shift on a pop, load a fresh list on an accept.
    always_comb
    begin
        for (int i = 0; i < rle8_pkg::MAX_RES; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        num_next = num_reg;
        if (pop)
        begin
            for (int i = 0; i < rle8_pkg::MAX_RES - 1; i++)
            begin
                slot_next[i] = slot_reg[i + 1];
            end
            num_next = num_reg - rle8_pkg::NUM_W'(1);
        end
        if (accept)
        begin
            for (int i = 0; i < rle8_pkg::MAX_RES; i++)
            begin
                slot_next[i] = lst[i];
            end
            num_next = lst_num;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_value_reg <= '0;
            held_count_reg <= '0;
            run_open_reg   <= 1'b0;
            num_reg        <= '0;
        end
        else
        begin
            held_value_reg <= held_value_next;
            held_count_reg <= held_count_next;
            run_open_reg   <= run_open_next;
            num_reg        <= num_next;
        end
    end

    // Payload slots need no reset.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < rle8_pkg::MAX_RES; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    // A pixel is never taken while a pair would stay waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ((num_reg == '0) || ((num_reg == rle8_pkg::NUM_W'(1)) && pop)))
        else $error("pixel accepted over waiting pairs");

    // The slot count never exceeds the slot array.
    a_num_range: assert property (@(posedge clk) disable iff (!rst_n)
        num_reg <= rle8_pkg::NUM_W'(rle8_pkg::MAX_RES))
        else $error("slot count out of range");

    // The end-of-file mark only rides on the end-of-file escape pair.
    a_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata == 16'h0100))
        else $error("last set on a pair that is not end of file");

    // An open run is never empty, a closed one holds no count.
    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        run_open_reg ? (held_count_reg != '0) : (held_count_reg == '0))
        else $error("run count disagrees with run state");

    // A row end leaves no run open.
    a_row_close: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && eol) |=> !run_open_reg)
        else $error("run left open after row end");

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the BMP RLE8 run encoder: directed table, random images, scoreboard.
`timescale 1ns / 100ps

module tb_top;

    typedef rle8_pkg::res_t res_t;

    // One group of pairs that a single pixel can cause.
    typedef res_t [0:rle8_pkg::MAX_RES-1] pair_set_t;

    // A row of the directed table; n_known > 0 means the pairs are typed in.
    typedef struct packed {
        logic [7:0] pixel;
        logic       row_end;
        logic       image_end;
        logic [2:0] n_known;
        pair_set_t  known;
    } pixel_row_t;

    localparam res_t NO_PAIR  = '0;
    localparam res_t EOL_PAIR = '{8'd0, rle8_pkg::ESC_EOL, 1'b0};
    localparam res_t EOF_PAIR = '{8'd0, rle8_pkg::ESC_EOF, 1'b1};
    localparam int   RANDOM_PIXELS = 380;

    // Directed stimulus: extremes first, then merges, the four-pair case and image restarts.
    localparam pixel_row_t DIRECTED [0:18] = '{
        '{8'h00, 1'b1, 1'b0, 3'd2, '{res_t'{8'd1, 8'h00, 1'b0}, EOL_PAIR, NO_PAIR, NO_PAIR}},
        '{8'hFF, 1'b0, 1'b1, 3'd3, '{res_t'{8'd1, 8'hFF, 1'b0}, EOL_PAIR, EOF_PAIR, NO_PAIR}},
        '{8'h00, 1'b1, 1'b1, 3'd3, '{res_t'{8'd1, 8'h00, 1'b0}, EOL_PAIR, EOF_PAIR, NO_PAIR}},
        '{8'hA5, 1'b0, 1'b0, 3'd0, '0},
        '{8'h5A, 1'b0, 1'b0, 3'd0, '0},
        '{8'h5A, 1'b0, 1'b0, 3'd0, '0},
        '{8'h5A, 1'b1, 1'b0, 3'd0, '0},
        '{8'hFF, 1'b0, 1'b0, 3'd0, '0},
        '{8'hFF, 1'b0, 1'b0, 3'd0, '0},
        '{8'h00, 1'b0, 1'b0, 3'd0, '0},
        '{8'h00, 1'b0, 1'b1, 3'd0, '0},
        '{8'h12, 1'b0, 1'b0, 3'd0, '0},
        '{8'h34, 1'b0, 1'b1, 3'd0, '0},
        '{8'h80, 1'b0, 1'b0, 3'd0, '0},
        '{8'h80, 1'b0, 1'b0, 3'd0, '0},
        '{8'h01, 1'b1, 1'b0, 3'd0, '0},
        '{8'h7F, 1'b1, 1'b1, 3'd0, '0},
        '{8'h7F, 1'b0, 1'b0, 3'd0, '0},
        '{8'hFE, 1'b1, 1'b0, 3'd0, '0}
    };

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // [7:0] pixel
    logic        s_tlast  = 1'b0;   // row_end
    logic        s_tuser  = 1'b0;   // image_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [7:0] run_count, [15:8] run_value
    logic        m_tlast;           // last

    // Encoder state mirrored by the predictor.
    logic [7:0] run_val    = 8'd0;
    logic [7:0] run_len    = 8'd0;
    logic       run_active = 1'b0;

    res_t pending_pairs[$];
    int   mismatches   = 0;
    int   pixels_sent  = 0;
    int   hold_cycles  = 0;
    bit   no_idle      = 1'b0;

    bmp_rle8_run_encoder_top DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Advance the run state by one pixel and list the pairs it releases, in output order.
    task automatic rle8_encode(input logic [7:0] px, input logic row_end,
                               input logic image_end, output pair_set_t pairs,
                               output int n);
        pairs = '0;
        n = 0;
        if (run_active && px == run_val && run_len != rle8_pkg::RUN_MAX)
        begin
            run_len = run_len + 8'd1;
        end
        else
        begin
            if (run_active)
            begin
                pairs[n] = '{run_len, run_val, 1'b0};
                n++;
            end
            run_val    = px;
            run_len    = 8'd1;
            run_active = 1'b1;
        end
        // Image end closes the row even without the row flag.
        if (row_end || image_end)
        begin
            pairs[n] = '{run_len, run_val, 1'b0};
            pairs[n + 1] = EOL_PAIR;
            n += 2;
            run_val    = 8'd0;
            run_len    = 8'd0;
            run_active = 1'b0;
        end
        if (image_end)
        begin
            pairs[n] = EOF_PAIR;
            n++;
        end
    endtask

    // Offer one pixel after a random gap and queue its pairs once it is taken.
    task automatic send_pixel(input logic [7:0] px, input logic row_end,
                              input logic image_end, input logic [2:0] n_known,
                              input pair_set_t known);
        int gap;
        int n;
        pair_set_t pairs;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tlast  <= row_end;
        s_tuser  <= image_end;
        do @(posedge clk); while (!s_tready);
        pixels_sent++;
        rle8_encode(px, row_end, image_end, pairs, n);
        if (n_known != 3'd0)
        begin
            pairs = known;
            n = n_known;
        end
        for (int i = 0; i < n; i++)
            pending_pairs.push_back(pairs[i]);
    endtask

    // Stop offering pixels until every queued pair has come out.
    task automatic drain_output();
        s_tvalid <= 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge clk);
    endtask

    // One random image: rows of runs, sometimes merging with the previous run, plus noise.
    task automatic send_image(input bit with_full_run);
        int rows;
        int runs;
        int len;
        int pick;
        logic [7:0] val;
        logic [7:0] prev_val;
        logic re;
        logic ie;
        prev_val = 8'd0;
        rows = $urandom_range(1, 4);
        for (int r = 0; r < rows; r++)
        begin
            runs = $urandom_range(1, 5);
            for (int k = 0; k < runs; k++)
            begin
                // Occasional stray pixel with random flags.
                if ($urandom_range(0, 7) == 0)
                    send_pixel(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                               $urandom_range(0, 3) == 0, 3'd0, '0);
                pick = $urandom_range(0, 15);
                len = (pick == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
                // Long enough to hit the length limit and start over with the same value.
                if (with_full_run && r == 0 && k == 0)
                    len = 258;
                val = ($urandom_range(0, 3) == 0) ? prev_val : 8'($urandom_range(0, 255));
                prev_val = val;
                for (int p = 0; p < len; p++)
                begin
                    re = (k == runs - 1) && (p == len - 1);
                    ie = re && (r == rows - 1);
                    if (ie && $urandom_range(0, 3) == 0)
                        re = 1'b0;
                    send_pixel(val, re, ie, 3'd0, '0);
                end
            end
        end
    endtask

    // Receiver: random stall before each pair, or a long hold when one is requested.
    initial
    begin : receiver
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            else
            begin
                stall = no_idle ? 0 : $urandom_range(0, 8);
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Compare every accepted pair with the oldest expected one.
    always @(posedge clk)
    begin : pair_check
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[7:0], m_tdata[15:8], m_tlast};
            if (pending_pairs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pair: count %0d value %0d last %0d",
                             got.run_count, got.run_value, got.last);
            end
            else
            begin
                want = pending_pairs.pop_front();
                if (got.run_count !== want.run_count || got.run_value !== want.run_value
                    || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pair error: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.run_count, want.run_value, want.last,
                                 got.run_count, got.run_value, got.last);
                end
            end
        end
    end

    // Main sequence: reset, directed table, random images, final drain.
    initial
    begin : stimulus
        int start;
        bit hold_done;
        bit drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_pixel(DIRECTED[i].pixel, DIRECTED[i].row_end, DIRECTED[i].image_end,
                       DIRECTED[i].n_known, DIRECTED[i].known);
        drain_output();

        start = pixels_sent;
        send_image(1'b1);
        while (pixels_sent - start < RANDOM_PIXELS)
        begin
            // Long output stall while pixels keep coming, so the input backs up.
            if (!hold_done && pixels_sent - start >= 260)
            begin
                hold_cycles = 300;
                hold_done = 1'b1;
            end
            // A stretch with no gaps on either side.
            no_idle = (pixels_sent - start >= 290) && (pixels_sent - start < 330);
            if (!drain_done && pixels_sent - start >= 340)
            begin
                drain_output();
                drain_done = 1'b1;
            end
            send_image(1'b0);
        end
        no_idle = 1'b0;
        drain_output();
        repeat (16) @(posedge clk);

        if (mismatches == 0)
            $display("bmp_rle8_run_encoder_top: match");
        else
            $display("bmp_rle8_run_encoder_top: mismatch");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2_000_000;
        $display("bmp_rle8_run_encoder_top: mismatch");
        $finish;
    end

endmodule
